/* rtl/msbag_pkg.sv */
package msbag_pkg;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int ENTRY_WIDTH_DEFAULT = 32;

   localparam int OP_W      = 2;
   localparam int VALUE_W   = 32;
   localparam int CNT_OUT_W = 5;
   localparam int LIMIT_W   = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic add_en;
      logic shift_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic active;
      logic found;
   } tok_type;

endpackage

/* rtl/msbag_req_if.sv */
interface msbag_req_if;
   logic                               valid;
   logic                               ready;
   msbag_pkg::op_type                  op;
   logic [msbag_pkg::VALUE_W-1:0]      entry_value;

   modport source (output valid, output op, output entry_value, input ready);
   modport sink   (input valid, input op, input entry_value, output ready);
endinterface

/* rtl/msbag_rsp_if.sv */
interface msbag_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               ok;
   logic [msbag_pkg::CNT_OUT_W-1:0]    frequency;
   logic [msbag_pkg::CNT_OUT_W-1:0]    entry_total;
   logic                               is_empty_flag;

   modport source (output valid, output ok, output frequency, output entry_total,
                   output is_empty_flag, input ready);
   modport sink   (input valid, input ok, input frequency, input entry_total,
                   input is_empty_flag, output ready);
endinterface

/* rtl/msbag_cell.sv */
module msbag_cell #(
   parameter int ENTRY_WIDTH = 32,
   parameter int CAPACITY    = 16,
   parameter int IDX         = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  msbag_pkg::cell_ctrl_type           ctrl,
   input  logic [ENTRY_WIDTH-1:0]             scan_value,
   input  logic [$clog2(CAPACITY+1)-1:0]      count,
   input  msbag_pkg::tok_type                 tok_in,
   input  logic [$clog2(CAPACITY+1)-1:0]      freq_in,
   input  logic [ENTRY_WIDTH-1:0]             next_entry,
   output msbag_pkg::tok_type                 tok_out,
   output logic [$clog2(CAPACITY+1)-1:0]      freq_out,
   output logic [ENTRY_WIDTH-1:0]             entry_out
);
   import msbag_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [ENTRY_WIDTH-1:0] entry_ff;
   tok_type                tok_ff;
   logic [CNT_W-1:0]       freq_ff;
   logic                   shift_ff;
   logic                   hit;

   assign hit = tok_in.active && (MY_IDX < count) && (entry_ff == scan_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         shift_ff <= 1'b0;
      end else begin
         tok_ff.active <= tok_in.active;
         tok_ff.found  <= tok_in.found | hit;
         if (tok_in.active) begin
            shift_ff <= tok_in.found | hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      freq_ff <= freq_in + CNT_W'(hit);
      if (ctrl.add_en && (count == MY_IDX)) begin
         entry_ff <= scan_value;
      end else if (ctrl.shift_en && shift_ff) begin
         entry_ff <= next_entry;
      end
   end

   assign tok_out   = tok_ff;
   assign freq_out  = freq_ff;
   assign entry_out = entry_ff;

endmodule

/* rtl/multiset_bag_store.sv */
// Channel   Direction  Payload
// req_chan  in         op, entry_value
// rsp_chan  out        ok, frequency, entry_total, is_empty_flag
// csr       in         csr_wr_en, csr_wr_data (entry limit)
//
// A new word is accepted only once the last one has been committed to the result register.
// Each search token walks down the row of entry cells, one per cycle, before the commit.
// The result register frees the input as soon as the result is loaded.
// Reset is synchronous and empties the bag; entry contents are not cleared.
// A stalled result holds off the next word's change to the bag until it is taken.
module multiset_bag_store #(
   parameter int CAPACITY    = msbag_pkg::CAPACITY_DEFAULT,
   parameter int ENTRY_WIDTH = msbag_pkg::ENTRY_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   msbag_req_if.sink                        req_chan,
   msbag_rsp_if.source                      rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [msbag_pkg::LIMIT_W-1:0]    csr_wr_data
);
   import msbag_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff;
   logic [ENTRY_WIDTH-1:0] value_ff;
   logic                   start_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [LIMIT_W-1:0]     limit_ff;
   logic [CNT_W-1:0]       freq_ff;
   logic                   found_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [CNT_OUT_W-1:0]   rsp_freq_ff, rsp_freq_in;
   logic [CNT_OUT_W-1:0]   rsp_total_ff;
   logic                   rsp_empty_ff;

   logic                   accept;
   logic                   commit;
   logic                   room;
   cell_ctrl_type          cell_ctrl;

   tok_type                tok_chain  [0:CAPACITY];
   logic [CNT_W-1:0]       freq_chain [0:CAPACITY];
   logic [ENTRY_WIDTH-1:0] entry_bus  [0:CAPACITY];

   assign accept = req_chan.valid && req_chan.ready;
   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign room   = (CMP_W'(count_ff) < CMP_W'(limit_ff)) && (count_ff < CNT_W'(CAPACITY));

   assign tok_chain[0].active = start_ff;
   assign tok_chain[0].found  = 1'b0;
   assign freq_chain[0]       = '0;
   assign entry_bus[CAPACITY] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         msbag_cell #(
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .CAPACITY    (CAPACITY),
            .IDX         (gi)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .scan_value (value_ff),
            .count      (count_ff),
            .tok_in     (tok_chain[gi]),
            .freq_in    (freq_chain[gi]),
            .next_entry (entry_bus[gi+1]),
            .tok_out    (tok_chain[gi+1]),
            .freq_out   (freq_chain[gi+1]),
            .entry_out  (entry_bus[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rsp_ok_in   = 1'b0;
      rsp_freq_in = CNT_OUT_W'(freq_ff);
      cell_ctrl   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_chain[CAPACITY].active) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      unique case (op_ff)
         OP_ADD: begin
            if (room) begin
               cell_ctrl.add_en = commit;
               count_in         = count_ff + 1'b1;
               rsp_ok_in        = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (found_ff) begin
               cell_ctrl.shift_en = commit;
               count_in           = count_ff - 1'b1;
               rsp_ok_in          = 1'b1;
            end
         end
         OP_QUERY: begin
            rsp_ok_in = found_ff;
         end
         OP_CLEAR: begin
            count_in    = '0;
            rsp_ok_in   = 1'b1;
            rsp_freq_in = '0;
         end
         default: begin
            rsp_ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_chan.op;
         value_ff <= ENTRY_WIDTH'(req_chan.entry_value);
      end
      if ((state_ff == ST_SCAN) && tok_chain[CAPACITY].active) begin
         freq_ff  <= freq_chain[CAPACITY];
         found_ff <= tok_chain[CAPACITY].found;
      end
      if (commit) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_freq_ff  <= rsp_freq_in;
         rsp_total_ff <= CNT_OUT_W'(count_in);
         rsp_empty_ff <= (count_in == '0);
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.ok            = rsp_ok_ff;
   assign rsp_chan.frequency     = rsp_freq_ff;
   assign rsp_chan.entry_total   = rsp_total_ff;
   assign rsp_chan.is_empty_flag = rsp_empty_ff;

   // The search token may only leave the end of the row while a scan is running.
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_chain[CAPACITY].active |-> (state_ff == ST_SCAN))
      else $error("search token left the cell row outside a scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> $past(state_ff == ST_DONE))
      else $error("entry count changed outside a commit");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ST_DONE))
      else $error("result word raised without a finished scan");

endmodule
